>>> rtl/hri_pkg.sv
// Shared constants for the Halton radical-inverse pipeline (bases 2, 3 and 5).
// No dependencies; imported by the top level and its assertion checker.
package hri_pkg;

	// Fixed field widths on the stream ports
	localparam int IDX_W   = 32;
	localparam int COORD_W = 32;
	localparam int S_TDATA_W = IDX_W;
	localparam int M_TDATA_W = 3 * COORD_W;

	// Constant division of a 32-bit value: q = (n * MULT) >> SHIFT
	localparam logic [31:0] DIV3_MULT  = 32'hAAAA_AAAB;
	localparam int          DIV3_SHIFT = 33;
	localparam logic [31:0] DIV5_MULT  = 32'hCCCC_CCCD;
	localparam int          DIV5_SHIFT = 34;

	// Upper bound on digits scanned when sizing the pipeline at elaboration
	localparam int MAX_DIGITS = 24;

endpackage

>>> rtl/halton_radical_inverse_2_3_5.sv
// Halton sample generator, bases 2, 3 and 5: one digit-per-stage pipeline.
// Depends on hri_pkg (division constants, field widths).
//
// Usage
//   Slave channel s_*: one transaction carries one sample index in s_tdata.
//   Master channel m_*: one transaction carries the three coordinates of
//   that index, each an unsigned Q0.FRAC_BITS fraction zero-extended to 32
//   bits. Results leave in the order the indices came in.
//   Index bits at and above INDEX_BITS are ignored.
// Stages and throughput
//   Stage k peels digit k off the index in base 3 and in base 5 (one
//   constant multiply-by-reciprocal per lane) and adds digit times
//   floor(2^FRAC_BITS / base^k) into the running sums. The number of
//   stages is the base-3 digit count, DEPTH: 20 at the defaults.
//   The base-2 coordinate is a plain bit reversal that rides along.
//   Throughput is one transaction per cycle while m_tready is high.
// Reset and stall
//   arst_n clears every stage valid bit at once; the payload registers
//   are left as they are. When m_tready is low the last stage holds its
//   result; earlier stages keep moving until they close up behind it, so
//   bubbles are squeezed out and s_tready drops only when all stages hold
//   data.
module halton_radical_inverse_2_3_5
	import hri_pkg::*;
#(
	parameter int INDEX_BITS = 32,
	parameter int FRAC_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// s_tdata[31:0]: sample_index
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// m_tdata[31:0]: coord_base2, [63:32]: coord_base3, [95:64]: coord_base5
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata
);

	// Digits of base b that matter: b^k must not exceed 2^FRAC_BITS (else the
	// weight is zero) and b^(k-1) must stay below 2^INDEX_BITS (else the
	// digit is always zero).
	function automatic int digits3();
		int          n;
		logic [63:0] p;
		n = 0;
		p = 64'd1;
		for (int k = 1; k <= MAX_DIGITS; k++) begin
			if ((p * 64'd3 <= (64'd1 << FRAC_BITS)) && (p < (64'd1 << INDEX_BITS)))
				n = k;
			p = p * 64'd3;
		end
		return n;
	endfunction

	function automatic int digits5();
		int          n;
		logic [63:0] p;
		n = 0;
		p = 64'd1;
		for (int k = 1; k <= MAX_DIGITS; k++) begin
			if ((p * 64'd5 <= (64'd1 << FRAC_BITS)) && (p < (64'd1 << INDEX_BITS)))
				n = k;
			p = p * 64'd5;
		end
		return n;
	endfunction

	// floor(2^FRAC_BITS / b^k), built as repeated floor division
	function automatic logic [63:0] weight3(input int k);
		logic [63:0] w;
		w = 64'd1 << FRAC_BITS;
		for (int i = 1; i <= MAX_DIGITS; i++) begin
			if (i <= k)
				w = w / 64'd3;
		end
		return w;
	endfunction

	function automatic logic [63:0] weight5(input int k);
		logic [63:0] w;
		w = 64'd1 << FRAC_BITS;
		for (int i = 1; i <= MAX_DIGITS; i++) begin
			if (i <= k)
				w = w / 64'd5;
		end
		return w;
	endfunction

	localparam int N3    = digits3();
	localparam int N5    = digits5();
	localparam int DEPTH = (N3 > N5) ? N3 : N5;
	localparam int REV_N = (FRAC_BITS < INDEX_BITS) ? FRAC_BITS : INDEX_BITS;

	// Stage 0 is the input side; stages 1..DEPTH are registers
	logic                  v_s    [0:DEPTH];
	logic [INDEX_BITS-1:0] n3_s   [0:DEPTH];
	logic [INDEX_BITS-1:0] n5_s   [0:DEPTH];
	logic [FRAC_BITS-1:0]  acc3_s [0:DEPTH];
	logic [FRAC_BITS-1:0]  acc5_s [0:DEPTH];
	logic [FRAC_BITS-1:0]  rev2_s [0:DEPTH];
	logic                  rdy    [1:DEPTH+1];

	logic [INDEX_BITS-1:0] in_idx;
	logic [FRAC_BITS-1:0]  in_rev;

	// Mask the index and mirror its bits for the base-2 coordinate
	assign in_idx = s_tdata[INDEX_BITS-1:0];

	always_comb begin
		in_rev = '0;
		for (int k = 1; k <= REV_N; k++)
			in_rev[FRAC_BITS-k] = in_idx[k-1];
	end

	assign v_s[0]    = s_tvalid;
	assign n3_s[0]   = in_idx;
	assign n5_s[0]   = in_idx;
	assign acc3_s[0] = '0;
	assign acc5_s[0] = '0;
	assign rev2_s[0] = in_rev;

	// A stage may load when it is empty or its successor is taking its item
	assign rdy[DEPTH+1] = m_tready;
	assign s_tready     = rdy[1];

	for (genvar j = 1; j <= DEPTH; j++) begin : g_stage
		localparam bit                   LIVE3 = (j <= N3);
		localparam bit                   LIVE5 = (j <= N5);
		localparam logic [FRAC_BITS-1:0] W3    = FRAC_BITS'(weight3(j));
		localparam logic [FRAC_BITS-1:0] W5    = FRAC_BITS'(weight5(j));

		logic [31:0]           n3_ext;
		logic [31:0]           n5_ext;
		logic [63:0]           p3;
		logic [63:0]           p5;
		logic [INDEX_BITS-1:0] q3;
		logic [INDEX_BITS-1:0] q5;
		logic [1:0]            d3;
		logic [2:0]            d5;
		logic [INDEX_BITS-1:0] n3_nx;
		logic [INDEX_BITS-1:0] n5_nx;
		logic [FRAC_BITS-1:0]  acc3_nx;
		logic [FRAC_BITS-1:0]  acc5_nx;

		assign rdy[j] = !v_s[j] || rdy[j+1];

		always_comb begin
			n3_ext = 32'(n3_s[j-1]);
			n5_ext = 32'(n5_s[j-1]);
			p3     = 64'(n3_ext) * 64'(DIV3_MULT);
			p5     = 64'(n5_ext) * 64'(DIV5_MULT);
			q3     = INDEX_BITS'(p3 >> DIV3_SHIFT);
			q5     = INDEX_BITS'(p5 >> DIV5_SHIFT);
			d3     = 2'(n3_ext - 32'(q3) * 32'd3);
			d5     = 3'(n5_ext - 32'(q5) * 32'd5);
			// lanes past their last useful digit pass through
			if (LIVE3) begin
				n3_nx   = q3;
				acc3_nx = acc3_s[j-1] + FRAC_BITS'(d3) * W3;
			end else begin
				n3_nx   = n3_s[j-1];
				acc3_nx = acc3_s[j-1];
			end
			if (LIVE5) begin
				n5_nx   = q5;
				acc5_nx = acc5_s[j-1] + FRAC_BITS'(d5) * W5;
			end else begin
				n5_nx   = n5_s[j-1];
				acc5_nx = acc5_s[j-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (rdy[j]) begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j] && v_s[j-1]) begin
				n3_s[j]   <= n3_nx;
				n5_s[j]   <= n5_nx;
				acc3_s[j] <= acc3_nx;
				acc5_s[j] <= acc5_nx;
				rev2_s[j] <= rev2_s[j-1];
			end
		end
	end

	// Last stage is the output register
	assign m_tvalid = v_s[DEPTH];
	assign m_tdata  = {COORD_W'(acc5_s[DEPTH]), COORD_W'(acc3_s[DEPTH]),
		COORD_W'(rev2_s[DEPTH])};

endmodule

>>> rtl/hri_chk.sv
// Port-level assertion checker for the Halton radical-inverse pipeline,
// bound to halton_radical_inverse_2_3_5. Depends on hri_pkg.
module hri_chk
	import hri_pkg::*;
#(
	parameter int INDEX_BITS = 32,
	parameter int FRAC_BITS  = 32
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// No result may appear while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("m_tvalid high during reset");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	// An empty output stage means the whole pipeline can take a transaction
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("s_tready low with output stage empty");

	// A waiting input transaction holds until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("waiting input transaction changed or dropped");

	// Index zero is the only index whose base-2 coordinate is zero, when all
	// index bits reach the fraction
	if (INDEX_BITS <= FRAC_BITS) begin : g_zero
		a_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
			m_tvalid && (m_tdata[COORD_W-1:0] == '0) |-> (m_tdata[M_TDATA_W-1:COORD_W] == '0))
			else $error("nonzero coordinate for index zero");
	end

endmodule

bind halton_radical_inverse_2_3_5 hri_chk #(
	.INDEX_BITS(INDEX_BITS),
	.FRAC_BITS (FRAC_BITS)
) u_hri_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
